// ----- src/bts_pkg.sv -----
// bts_pkg: shared types, constants and the control-store program for the binary trie insert
// block. No dependencies. Used by bts_node_store and binary_trie_string_insert.
package bts_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int TAG_WIDTH_DEF = 16;
	localparam int BITS_PER_CHAR = 7;
	localparam int BIT_IDX_W = $clog2(BITS_PER_CHAR);
	localparam int CHAR_W = 7;
	localparam int TAG_IN_W = 16;
	localparam int END_W = 10;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_STORED = 2'd1,
		ST_DUP = 2'd2,
		ST_FULL = 2'd3
	} bts_status_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic char_valid;
		logic last_char;
		logic [TAG_IN_W-1:0] tag_value;
	} bts_item_t;

	typedef struct packed {
		bts_status_t status;
		logic [END_W-1:0] end_node;
	} bts_result_t;

	// write enables toward the node store
	typedef struct packed {
		logic lk0_we;
		logic lk1_we;
		logic tg_we;
	} bts_store_ctl_t;

	typedef enum logic [2:0] {
		P_IDLE,
		P_RD,
		P_EV,
		P_TAG,
		P_TEV
	} bts_step_t;

	typedef enum logic [2:0] {
		ACT_IDLE,
		ACT_RD,
		ACT_EV,
		ACT_TAG,
		ACT_TEV
	} bts_act_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_START,
		C_WALK,
		C_MORE
	} bts_cond_t;

	typedef struct packed {
		bts_act_t act;
		bts_cond_t cond;
		bts_step_t tgt_t;
		bts_step_t tgt_f;
	} bts_uword_t;

	function automatic bts_uword_t ucode_rom(input bts_step_t pc);
		bts_uword_t w;
		unique case (pc)
			P_IDLE: w = '{act: ACT_IDLE, cond: C_START, tgt_t: P_RD, tgt_f: P_IDLE};
			P_RD: w = '{act: ACT_RD, cond: C_WALK, tgt_t: P_EV, tgt_f: P_TAG};
			P_EV: w = '{act: ACT_EV, cond: C_MORE, tgt_t: P_EV, tgt_f: P_TAG};
			P_TAG: w = '{act: ACT_TAG, cond: C_ALWAYS, tgt_t: P_TEV, tgt_f: P_TEV};
			P_TEV: w = '{act: ACT_TEV, cond: C_ALWAYS, tgt_t: P_IDLE, tgt_f: P_IDLE};
			default: w = '{act: ACT_IDLE, cond: C_ALWAYS, tgt_t: P_IDLE, tgt_f: P_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- src/bts_node_store.sv -----
// bts_node_store: child link tables and tag table of the trie, root entry held in flops.
// Depends on bts_pkg.
module bts_node_store
	import bts_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input bts_store_ctl_t ctl,
	input logic [$clog2(MAX_NODES)-1:0] lk_rd_addr,
	input logic [$clog2(MAX_NODES)-1:0] lk_wr_addr,
	input logic [$clog2(MAX_NODES):0] lk0_wdata,
	input logic [$clog2(MAX_NODES):0] lk1_wdata,
	output logic [$clog2(MAX_NODES):0] lk0_rdata,
	output logic [$clog2(MAX_NODES):0] lk1_rdata,
	input logic [$clog2(MAX_NODES)-1:0] tg_rd_addr,
	input logic [$clog2(MAX_NODES)-1:0] tg_wr_addr,
	input logic [TAG_WIDTH:0] tg_wdata,
	output logic [TAG_WIDTH:0] tg_rdata
);

	localparam int NW = $clog2(MAX_NODES);

	logic [NW:0] zero_mem [MAX_NODES];
	logic [NW:0] one_mem [MAX_NODES];
	logic [TAG_WIDTH:0] tag_mem [MAX_NODES];

	logic [NW:0] lk0_mem_q;
	logic [NW:0] lk1_mem_q;
	logic [TAG_WIDTH:0] tg_mem_q;
	logic lk_root_q;
	logic tg_root_q;
	logic [NW:0] root0_q;
	logic [NW:0] root1_q;
	logic [TAG_WIDTH:0] root_tag_q;

	always_ff @(posedge clk) begin
		if (ctl.lk0_we) begin
			zero_mem[lk_wr_addr] <= lk0_wdata;
		end
		if (ctl.lk1_we) begin
			one_mem[lk_wr_addr] <= lk1_wdata;
		end
		lk0_mem_q <= zero_mem[lk_rd_addr];
		lk1_mem_q <= one_mem[lk_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.tg_we) begin
			tag_mem[tg_wr_addr] <= tg_wdata;
		end
		tg_mem_q <= tag_mem[tg_rd_addr];
	end

	// root entry: empty and untagged after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root0_q <= '0;
			root1_q <= '0;
			root_tag_q <= '0;
			lk_root_q <= 1'b0;
			tg_root_q <= 1'b0;
		end else begin
			if (ctl.lk0_we && lk_wr_addr == '0) begin
				root0_q <= lk0_wdata;
			end
			if (ctl.lk1_we && lk_wr_addr == '0) begin
				root1_q <= lk1_wdata;
			end
			if (ctl.tg_we && tg_wr_addr == '0) begin
				root_tag_q <= tg_wdata;
			end
			lk_root_q <= (lk_rd_addr == '0);
			tg_root_q <= (tg_rd_addr == '0);
		end
	end

	assign lk0_rdata = lk_root_q ? root0_q : lk0_mem_q;
	assign lk1_rdata = lk_root_q ? root1_q : lk1_mem_q;
	assign tg_rdata = tg_root_q ? root_tag_q : tg_mem_q;

endmodule

// ----- src/binary_trie_string_insert.sv -----
// binary_trie_string_insert: top level, control-store sequencer and walk datapath.
// Depends on bts_pkg and bts_node_store.
// Sequence: an accepted item passes through RD, one EV walk step per character bit (fewer
// when the table fills, none for an empty item), TAG and TEV; the result strobe is registered
// from TEV. A new item is taken only in idle, after the last one is through; the walk takes one
// trie level per cycle through the single read port of the link tables. No result stall.
// Reset: control clears, root empty and untagged at once; nodes are cleared when allocated.
module binary_trie_string_insert
	import bts_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bts_item_t item,
	output logic done,
	output bts_result_t result
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = NW + 1;

	bts_step_t pc_q;
	bts_step_t pc_d;
	bts_uword_t uw;
	logic cond_hit;

	logic [BIT_IDX_W-1:0] k_q;
	logic [CHAR_W-1:0] code_q;
	logic valid_q;
	logic last_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [NW-1:0] cursor_q;
	logic [CW-1:0] count_q;
	logic ovf_q;
	logic fresh_q;
	logic done_q;
	bts_result_t result_q;

	bts_store_ctl_t ctl;
	logic [NW-1:0] lk_rd_addr;
	logic [NW-1:0] lk_wr_addr;
	logic [NW:0] lk0_wdata;
	logic [NW:0] lk1_wdata;
	logic [NW:0] lk0_rdata;
	logic [NW:0] lk1_rdata;
	logic [NW-1:0] tg_wr_addr;
	logic [TAG_WIDTH:0] tg_wdata;
	logic [TAG_WIDTH:0] tg_rdata;

	logic [NW:0] cur_z;
	logic [NW:0] cur_o;
	logic [NW:0] sel_link;
	logic [NW:0] new_link;
	logic bit_v;
	logic have;
	logic full;
	logic stop;
	logic [NW-1:0] new_idx;
	logic [NW-1:0] nxt;
	logic do_store;
	bts_status_t status_d;
	logic [31:0] cur_ext;

	bts_node_store #(
		.MAX_NODES(MAX_NODES),
		.TAG_WIDTH(TAG_WIDTH)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.lk_rd_addr(lk_rd_addr),
		.lk_wr_addr(lk_wr_addr),
		.lk0_wdata(lk0_wdata),
		.lk1_wdata(lk1_wdata),
		.lk0_rdata(lk0_rdata),
		.lk1_rdata(lk1_rdata),
		.tg_rd_addr(cursor_q),
		.tg_wr_addr(tg_wr_addr),
		.tg_wdata(tg_wdata),
		.tg_rdata(tg_rdata)
	);

	assign uw = ucode_rom(pc_q);

	// a node allocated on this walk has empty links whatever the table holds
	assign cur_z = fresh_q ? '0 : lk0_rdata;
	assign cur_o = fresh_q ? '0 : lk1_rdata;
	assign bit_v = code_q[k_q];
	assign sel_link = bit_v ? cur_o : cur_z;
	assign have = sel_link[NW];
	assign full = (count_q >= CW'(MAX_NODES));
	assign stop = !have && full;
	assign new_idx = count_q[NW-1:0];
	assign new_link = {1'b1, new_idx};
	assign nxt = have ? sel_link[NW-1:0] : new_idx;

	assign do_store = !ovf_q && last_q && !tg_rdata[TAG_WIDTH];
	assign cur_ext = 32'(cursor_q);

	always_comb begin
		if (ovf_q) begin
			status_d = ST_FULL;
		end else if (!last_q) begin
			status_d = ST_ACCEPT;
		end else if (tg_rdata[TAG_WIDTH]) begin
			status_d = ST_DUP;
		end else begin
			status_d = ST_STORED;
		end
	end

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS: cond_hit = 1'b1;
			C_START: cond_hit = start;
			C_WALK: cond_hit = valid_q && !ovf_q;
			C_MORE: cond_hit = (k_q != '0) && !stop;
			default: cond_hit = 1'b0;
		endcase
		pc_d = cond_hit ? uw.tgt_t : uw.tgt_f;
	end

	always_comb begin
		ctl = '0;
		lk_rd_addr = cursor_q;
		lk_wr_addr = cursor_q;
		lk0_wdata = '0;
		lk1_wdata = '0;
		tg_wr_addr = cursor_q;
		tg_wdata = {1'b1, tag_q};
		unique case (uw.act)
			ACT_EV: begin
				lk_rd_addr = nxt;
				if (!have && !full) begin
					// set the taken link; a fresh parent also gets its other link cleared
					ctl.lk1_we = bit_v || fresh_q;
					ctl.lk0_we = !bit_v || fresh_q;
					lk1_wdata = bit_v ? new_link : '0;
					lk0_wdata = bit_v ? '0 : new_link;
					ctl.tg_we = 1'b1;
					tg_wr_addr = new_idx;
					tg_wdata = '0;
				end
			end
			ACT_TAG: begin
				// a leaf allocated on this walk gets empty links
				ctl.lk0_we = fresh_q;
				ctl.lk1_we = fresh_q;
			end
			ACT_TEV: begin
				ctl.tg_we = do_store;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
			k_q <= '0;
			cursor_q <= '0;
			count_q <= CW'(1);
			ovf_q <= 1'b0;
			fresh_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			done_q <= (uw.act == ACT_TEV);
			unique case (uw.act)
				ACT_RD: begin
					k_q <= BIT_IDX_W'(BITS_PER_CHAR - 1);
				end
				ACT_EV: begin
					k_q <= k_q - 1'b1;
					if (stop) begin
						ovf_q <= 1'b1;
					end else begin
						cursor_q <= nxt;
						fresh_q <= !have;
						if (!have) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ACT_TAG: begin
					fresh_q <= 1'b0;
				end
				ACT_TEV: begin
					if (last_q) begin
						cursor_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (uw.act == ACT_IDLE && start) begin
			code_q <= item.char_code;
			valid_q <= item.char_valid;
			last_q <= item.last_char;
			tag_q <= TAG_WIDTH'(item.tag_value);
		end
		if (uw.act == ACT_TEV) begin
			result_q.status <= status_d;
			result_q.end_node <= cur_ext[END_W-1:0];
		end
	end

	assign busy = (pc_q != P_IDLE);
	assign done = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still running");

	a_count_rng: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CW'(MAX_NODES)))
		else $error("node count out of range");

	a_cursor_rng: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(cursor_q) < count_q)
		else $error("cursor points at an unallocated node");

	a_fresh_last: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> (count_q == CW'(cursor_q) + CW'(1)))
		else $error("fresh node is not the newest allocation");

	a_accept_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (pc_q == P_RD))
		else $error("accepted transaction did not enter the walk");

endmodule
